@@ rtl/sedd_pkg.sv @@
`default_nettype none

package sedd_pkg;

  // Sample, carried error and raw sum widths.
  localparam int SAMPLE_W = 8;
  localparam int ERR_W    = 9;
  localparam int SUM_W    = 10;
  localparam int INDEX_W  = 8;

  // Full-scale sample value used by the clamp.
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

endpackage

`default_nettype wire

@@ rtl/sedd_pix_if.sv @@
`default_nettype none

// Pixel channel: one RGB or gray word per handshake.
interface sedd_pix_if import sedd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red;
  logic [SAMPLE_W-1:0] green;
  logic [SAMPLE_W-1:0] blue;
  logic                gray_mode;
  logic                row_end;

  modport source (output valid, red, green, blue, gray_mode, row_end, input ready);
  modport sink   (input valid, red, green, blue, gray_mode, row_end, output ready);
endinterface

`default_nettype wire

@@ rtl/sedd_idx_if.sv @@
`default_nettype none

// Result channel: one palette index word per handshake.
interface sedd_idx_if import sedd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] color_index;
  logic               row_reversed;

  modport source (output valid, color_index, row_reversed, input ready);
  modport sink   (input valid, color_index, row_reversed, output ready);
endinterface

`default_nettype wire

@@ rtl/sedd_quant.sv @@
`default_nettype none

// One channel of the quantizer: add the carried error, clamp, quantize and
// compute the error left for the next pixel. Purely combinational.
module sedd_quant import sedd_pkg::*; #(
  parameter int LEVELS = 5
) (
  input  wire logic [SAMPLE_W-1:0]        sample_i,
  input  wire logic signed [ERR_W-1:0]    err_i,
  output logic [$clog2(LEVELS)-1:0]       lvl_o,
  output logic signed [ERR_W-1:0]         err_o
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PROD_W = SAMPLE_W + LVL_W;

  logic signed [SUM_W-1:0]  sum;
  logic [SAMPLE_W-1:0]      clamped;
  logic [PROD_W-1:0]        prod;
  logic [SAMPLE_W-1:0]      recon_tab [LEVELS];
  logic [SAMPLE_W-1:0]      recon;

  // Reconstruction level of each quantizer step, fixed at elaboration.
  for (genvar k = 0; k < LEVELS; k++) begin : g_recon
    localparam int Recon = k * 255 / (LEVELS - 1);
    assign recon_tab[k] = SAMPLE_W'(Recon);
  end

  // Error plus sample, clamped to the sample range.
  assign sum = SUM_W'(err_i) + $signed({2'b00, sample_i});

  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed({2'b00, SAMPLE_MAX})) begin
      clamped = SAMPLE_MAX;
    end else begin
      clamped = sum[SAMPLE_W-1:0];
    end
  end

  // Level is the top bits of clamped * LEVELS / 256.
  assign prod  = PROD_W'(clamped) * PROD_W'(LEVELS);
  assign lvl_o = prod[PROD_W-1:SAMPLE_W];

  // New error is the clamped value minus the reconstructed level.
  assign recon = recon_tab[lvl_o];
  assign err_o = ERR_W'($signed({1'b0, clamped}) - $signed({1'b0, recon}));

endmodule

`default_nettype wire

@@ rtl/serpentine_error_diffusion_dither.sv @@
// Path: an accepted word is held in the input register, and its palette index is
// registered in the result register, from which the index can be taken.
// Throughput: one pixel per cycle while the result side is not stalled; the carried
// error loop closes through the channel quantizers between the input and result registers.
// Reset: asynchronous, active low; empties both registers, clears all carried
// errors and both row-direction flags (first row runs forward).
`default_nettype none

module serpentine_error_diffusion_dither import sedd_pkg::*; #(
  parameter int RED_LEVELS   = 5,
  parameter int GREEN_LEVELS = 8,
  parameter int BLUE_LEVELS  = 5,
  parameter int GRAY_LEVELS  = 24,
  parameter int CUBE_BASE    = 56,
  parameter int GRAY_BASE    = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sedd_pix_if.sink       pix_i,
  sedd_idx_if.source     idx_o
);

  localparam int RED_W   = $clog2(RED_LEVELS);
  localparam int GREEN_W = $clog2(GREEN_LEVELS);
  localparam int BLUE_W  = $clog2(BLUE_LEVELS);
  localparam int GRAY_W  = $clog2(GRAY_LEVELS);

  // Input register.
  logic                in_valid_q;
  logic [SAMPLE_W-1:0] red_q, green_q, blue_q;
  logic                gray_q, row_end_q;

  // Result register.
  logic                out_valid_q;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic                rev_q, rev_d;

  // Carried state.
  logic signed [ERR_W-1:0] red_err_q, green_err_q, blue_err_q, gray_err_q;
  logic signed [ERR_W-1:0] red_err_d, green_err_d, blue_err_d, gray_err_d;
  logic                    color_flag_q, gray_flag_q;

  logic [RED_W-1:0]   red_lvl;
  logic [GREEN_W-1:0] green_lvl;
  logic [BLUE_W-1:0]  blue_lvl;
  logic [GRAY_W-1:0]  gray_lvl;

  logic advance;

  // The result register frees up when empty or when its word is taken.
  assign advance     = !out_valid_q || idx_o.ready;
  assign pix_i.ready = !in_valid_q || advance;

  // Channel quantizers; gray mode reads its sample from the red field.
  sedd_quant #(.LEVELS(RED_LEVELS)) u_red (
    .sample_i(red_q), .err_i(red_err_q), .lvl_o(red_lvl), .err_o(red_err_d)
  );
  sedd_quant #(.LEVELS(GREEN_LEVELS)) u_green (
    .sample_i(green_q), .err_i(green_err_q), .lvl_o(green_lvl), .err_o(green_err_d)
  );
  sedd_quant #(.LEVELS(BLUE_LEVELS)) u_blue (
    .sample_i(blue_q), .err_i(blue_err_q), .lvl_o(blue_lvl), .err_o(blue_err_d)
  );
  sedd_quant #(.LEVELS(GRAY_LEVELS)) u_gray (
    .sample_i(red_q), .err_i(gray_err_q), .lvl_o(gray_lvl), .err_o(gray_err_d)
  );

  // Palette index, wrapping modulo 256, and the active mode's direction.
  always_comb begin
    if (gray_q) begin
      index_d = INDEX_W'(GRAY_BASE) + INDEX_W'(gray_lvl);
      rev_d   = gray_flag_q;
    end else begin
      index_d = INDEX_W'(CUBE_BASE)
              + (INDEX_W'(blue_lvl) * INDEX_W'(RED_LEVELS) + INDEX_W'(red_lvl))
                * INDEX_W'(GREEN_LEVELS)
              + INDEX_W'(green_lvl);
      rev_d   = color_flag_q;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_valid_q <= pix_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      red_q     <= pix_i.red;
      green_q   <= pix_i.green;
      blue_q    <= pix_i.blue;
      gray_q    <= pix_i.gray_mode;
      row_end_q <= pix_i.row_end;
    end
  end

  // Result register control and carried state of the active mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      red_err_q    <= '0;
      green_err_q  <= '0;
      blue_err_q   <= '0;
      gray_err_q   <= '0;
      color_flag_q <= 1'b0;
      gray_flag_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        if (gray_q) begin
          gray_err_q <= gray_err_d;
          if (row_end_q) begin
            gray_flag_q <= !gray_flag_q;
          end
        end else begin
          red_err_q   <= red_err_d;
          green_err_q <= green_err_d;
          blue_err_q  <= blue_err_d;
          if (row_end_q) begin
            color_flag_q <= !color_flag_q;
          end
        end
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      index_q <= index_d;
      rev_q   <= rev_d;
    end
  end

  assign idx_o.valid        = out_valid_q;
  assign idx_o.color_index  = index_q;
  assign idx_o.row_reversed = rev_q;

  // A word held in the input register is never dropped while stalled.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input word lost while stalled");

  // A result disappears only after it was taken.
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(idx_o.ready))
    else $error("result dropped without handshake");

  // Gray pixels leave the color errors and flag untouched.
  a_gray_isolated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && gray_q |=>
      $stable(red_err_q) && $stable(green_err_q) && $stable(blue_err_q)
      && $stable(color_flag_q))
    else $error("gray pixel disturbed color state");

  // A color row end flips the color direction flag.
  a_color_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && !gray_q && row_end_q |=>
      color_flag_q != $past(color_flag_q))
    else $error("color direction flag did not toggle at row end");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sedd_pkg::*;

  // Palette layout of the block under test.
  localparam int RED_LEVELS   = 5;
  localparam int GREEN_LEVELS = 8;
  localparam int BLUE_LEVELS  = 5;
  localparam int GRAY_LEVELS  = 24;
  localparam int CUBE_BASE    = 56;
  localparam int GRAY_BASE    = 32;

  localparam int RANDOM_PIXELS = 1400;
  // Once fewer pixels than this are pending, both sides start no new idle bursts.
  localparam int TAIL_PIXELS   = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                gray_mode;
    logic                row_end;
  } pixel_word_t;

  typedef struct {
    logic [INDEX_W-1:0] color_index;
    logic               row_reversed;
  } palette_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sedd_pix_if pix ();
  sedd_idx_if idx ();

  serpentine_error_diffusion_dither #(
    .RED_LEVELS  (RED_LEVELS),
    .GREEN_LEVELS(GREEN_LEVELS),
    .BLUE_LEVELS (BLUE_LEVELS),
    .GRAY_LEVELS (GRAY_LEVELS),
    .CUBE_BASE   (CUBE_BASE),
    .GRAY_BASE   (GRAY_BASE)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .idx_o (idx)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pixel_word_t   pixel_q[$];
  palette_word_t palette_q[$];

  // Dither state mirrored from the block.
  int   red_err, green_err, blue_err, gray_err;
  logic color_rev, gray_rev;

  int fail_count;
  int color_pixels, gray_pixels, row_ends, checked_words;
  int send_gap, stall_left;
  logic tail_phase;

  assign tail_phase = (pixel_q.size() < TAIL_PIXELS);

  // Adds the carried error, clamps to the sample range, and returns the level.
  // The leftover against the reconstructed level is carried forward.
  function automatic int quantize_sample(input int sample, ref int err, input int levels);
    int sum;
    int lvl;
    sum = err + sample;
    if (sum < 0) sum = 0;
    else if (sum > int'(SAMPLE_MAX)) sum = int'(SAMPLE_MAX);
    lvl = (sum * levels) / (int'(SAMPLE_MAX) + 1);
    err = sum - (lvl * int'(SAMPLE_MAX)) / (levels - 1);
    return lvl;
  endfunction

  // Works out the palette word for one pixel and advances the dither state.
  function automatic palette_word_t dither_pixel(input pixel_word_t w);
    palette_word_t res;
    int rl, gl, bl;
    if (w.gray_mode) begin
      gl = quantize_sample(int'(w.red), gray_err, GRAY_LEVELS);
      res.color_index  = INDEX_W'(GRAY_BASE + gl);
      res.row_reversed = gray_rev;
      if (w.row_end) gray_rev = ~gray_rev;
    end else begin
      rl = quantize_sample(int'(w.red), red_err, RED_LEVELS);
      gl = quantize_sample(int'(w.green), green_err, GREEN_LEVELS);
      bl = quantize_sample(int'(w.blue), blue_err, BLUE_LEVELS);
      res.color_index  = INDEX_W'(CUBE_BASE + (bl * RED_LEVELS + rl) * GREEN_LEVELS + gl);
      res.row_reversed = color_rev;
      if (w.row_end) color_rev = ~color_rev;
    end
    return res;
  endfunction

  task automatic add_pixel(input int r, input int g, input int b, input bit gray,
                           input bit last);
    pixel_word_t w;
    w.red       = SAMPLE_W'(r);
    w.green     = SAMPLE_W'(g);
    w.blue      = SAMPLE_W'(b);
    w.gray_mode = gray;
    w.row_end   = last;
    pixel_q.push_back(w);
  endtask

  // Sample content by style: uniform, ramp, full-scale extremes, or a flat area.
  function automatic int pick_sample(input int style, input int pos, input int start,
                                     input int step);
    int ext;
    case (style)
      0: return $urandom_range(0, 255);
      1: return (start + pos * step) & 8'hff;
      2: begin
        ext = $urandom_range(0, 3);
        return (ext == 0) ? 0 : (ext == 1) ? 255 : (ext == 2) ? 1 : 254;
      end
      default: begin
        ext = start + $urandom_range(0, 6) - 3;
        return (ext < 0) ? 0 : (ext > 255) ? 255 : ext;
      end
    endcase
  endfunction

  // Driver: presents pending pixels and predicts each one at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_word_t w;
    if (!rst_ni) begin
      pix.valid     <= 1'b0;
      pix.red       <= '0;
      pix.green     <= '0;
      pix.blue      <= '0;
      pix.gray_mode <= 1'b0;
      pix.row_end   <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (pix.valid && pix.ready) begin
        w.red       = pix.red;
        w.green     = pix.green;
        w.blue      = pix.blue;
        w.gray_mode = pix.gray_mode;
        w.row_end   = pix.row_end;
        palette_q.push_back(dither_pixel(w));
        if (w.gray_mode) gray_pixels++;
        else color_pixels++;
        if (w.row_end) row_ends++;
      end
      if (!pix.valid || pix.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          pix.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
          send_gap  <= $urandom_range(0, 14);
          pix.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          w = pixel_q.pop_front();
          pix.valid     <= 1'b1;
          pix.red       <= w.red;
          pix.green     <= w.green;
          pix.blue      <= w.blue;
          pix.gray_mode <= w.gray_mode;
          pix.row_end   <= w.row_end;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx.ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      idx.ready  <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      idx.ready  <= 1'b0;
    end else begin
      idx.ready <= 1'b1;
    end
  end

  // Monitor: compares each palette word with the oldest prediction.
  always @(posedge clk_i) begin
    palette_word_t exp_w;
    if (rst_ni && idx.valid && idx.ready) begin
      if (palette_q.size() == 0) begin
        $display("%0t: unexpected palette word, expected none, got index %0d rev %0b",
                 $time, idx.color_index, idx.row_reversed);
        fail_count++;
      end else begin
        exp_w = palette_q.pop_front();
        checked_words++;
        if (idx.color_index !== exp_w.color_index) begin
          $display("%0t: color_index mismatch, expected %0d, got %0d",
                   $time, exp_w.color_index, idx.color_index);
          fail_count++;
        end
        if (idx.row_reversed !== exp_w.row_reversed) begin
          $display("%0t: row_reversed mismatch, expected %0b, got %0b",
                   $time, exp_w.row_reversed, idx.row_reversed);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int queued, row_len, style_r, style_g, style_b, start, step, flip_at;
    bit gray;
    rst_ni        = 1'b0;
    pix.valid     = 1'b0;
    pix.red       = '0;
    pix.green     = '0;
    pix.blue      = '0;
    pix.gray_mode = 1'b0;
    pix.row_end   = 1'b0;
    idx.ready     = 1'b0;
    red_err = 0; green_err = 0; blue_err = 0; gray_err = 0;
    color_rev = 1'b0;
    gray_rev  = 1'b0;
    fail_count = 0;
    color_pixels = 0; gray_pixels = 0; row_ends = 0; checked_words = 0;

    // Directed: extremes, clamping both ways, row ends in each mode, and
    // interleaved modes that must leave each other's state alone.
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(255, 255, 255, 0, 0);
    add_pixel(230, 230, 230, 0, 0);   // negative error carried
    add_pixel(0, 0, 0, 0, 0);         // sum below zero clamps
    add_pixel(25, 25, 25, 0, 0);      // positive error carried
    add_pixel(255, 255, 255, 0, 0);   // sum above full scale clamps
    add_pixel(128, 64, 192, 0, 1);
    add_pixel(250, 255, 255, 1, 0);   // green and blue are ignored in gray mode
    add_pixel(0, 0, 0, 1, 0);
    add_pixel(10, 255, 0, 1, 0);
    add_pixel(255, 0, 255, 1, 0);
    add_pixel(128, 128, 128, 1, 1);
    add_pixel(100, 200, 50, 0, 0);
    add_pixel(77, 1, 2, 1, 0);
    add_pixel(255, 0, 255, 0, 1);
    add_pixel(1, 254, 1, 1, 1);
    add_pixel(0, 255, 0, 0, 1);
    add_pixel(17, 34, 51, 0, 1);
    add_pixel(254, 127, 128, 1, 1);
    add_pixel(254, 1, 254, 0, 0);

    // Random rows in one mode ending with row_end; some rows get a stray
    // pixel of the other mode or lose their row end.
    queued = 0;
    while (queued < RANDOM_PIXELS) begin
      gray    = ($urandom_range(0, 9) < 4);
      row_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      style_r = $urandom_range(0, 3);
      style_g = $urandom_range(0, 3);
      style_b = $urandom_range(0, 3);
      start   = $urandom_range(0, 255);
      step    = $urandom_range(0, 12);
      flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, row_len - 1) : -1;
      for (int p = 0; p < row_len; p++) begin
        add_pixel(pick_sample(style_r, p, start, step),
                  pick_sample(style_g, p, 255 - start, step),
                  pick_sample(style_b, p, start ^ 8'h5a, step),
                  (p == flip_at) ? !gray : gray,
                  (p == row_len - 1) ? ($urandom_range(0, 11) != 0)
                                     : ($urandom_range(0, 59) == 0));
      end
      queued += row_len;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixel_q.size() != 0 || pix.valid) @(posedge clk_i);
    while (palette_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d color and %0d gray pixels with %0d row ends; %0d palette words checked.",
             color_pixels, gray_pixels, row_ends, checked_words);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d pixels pending and %0d palette words outstanding",
             $time, pixel_q.size(), palette_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ serpentine_error_diffusion_dither.f @@
rtl/sedd_pkg.sv
rtl/sedd_pix_if.sv
rtl/sedd_idx_if.sv
rtl/sedd_quant.sv
rtl/serpentine_error_diffusion_dither.sv
dv/tb.sv
